// ----- hw/rtl/cat_pkg.sv -----
// ----------------------------------------------------------------------------
// cat_pkg
// Shared types and constants for the connection activity tracker: item
// payloads, table entry layout, status codes and register map.
// ----------------------------------------------------------------------------
package cat_pkg;

    localparam int TABLE_ENTRIES = 128;

    localparam logic [31:0] LOOPBACK_ADDR     = 32'h7F00_0001;
    localparam logic [3:0]  STATE_ESTABLISHED = 4'd1;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_IGNORED  = 3'd3;
    localparam logic [2:0] ST_SCAN_END = 3'd4;

    localparam logic ACT_OBSERVE  = 1'b0;
    localparam logic ACT_SCAN_END = 1'b1;

    localparam logic [2:0] REG_ACTIVE_LIMIT = 3'd0;
    localparam logic [2:0] REG_CLIENT_LIMIT = 3'd1;
    localparam logic [2:0] REG_AGE_LIMIT    = 3'd2;
    localparam logic [2:0] REG_COUNT_CONN   = 3'd3;
    localparam logic [2:0] REG_COUNT_LISTEN = 3'd4;

    localparam logic [7:0] ACTIVE_LIMIT_RST = 8'd50;
    localparam logic [7:0] CLIENT_LIMIT_RST = 8'd10;
    localparam logic [7:0] AGE_LIMIT_RST    = 8'd10;
    localparam logic       COUNT_CONN_RST   = 1'b1;
    localparam logic       COUNT_LISTEN_RST = 1'b0;

    typedef struct packed {
        logic        action;
        logic [3:0]  conn_state;
        logic [31:0] remote_addr;
        logic [15:0] remote_port;
        logic [31:0] tx_queue;
        logic [31:0] rx_queue;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        active_client;
        logic [31:0] max_tx_queue;
    } out_item_t;

    typedef struct packed {
        logic [15:0] port;
        logic [31:0] tx;
        logic [31:0] rx;
        logic [7:0]  repeats;
        logic [31:0] last_scan;
    } entry_t;

endpackage

// ----- hw/rtl/connection_activity_tracker_top.sv -----
// ----------------------------------------------------------------------------
// connection_activity_tracker_top
// Processing: an ignored observe goes straight to the result; other observes
//   and end of scan step through the table at one table read per cycle.
// Throughput: one item at a time; next transfer once the result is registered.
// Reset: synchronous, active low; a clearing pass zeroes every table entry
//   before the first input transfer.
// ----------------------------------------------------------------------------
module connection_activity_tracker_top #(
    parameter int TABLE_ENTRIES = cat_pkg::TABLE_ENTRIES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cat_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cat_pkg::out_item_t  m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_OBS_SCAN,
        S_OBS_WRITE,
        S_END_SCAN,
        S_RESULT
    } state_t;

    state_t               state_reg, state_next;
    cat_pkg::in_item_t    in_reg, in_next;
    logic [CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic                 rdv_reg, rdv_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    cat_pkg::entry_t      hit_ent_reg, hit_ent_next;
    logic                 act_reg, act_next;
    cat_pkg::out_item_t   res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    cat_pkg::out_item_t   m_data_reg, m_data_next;
    logic [31:0]          scan_num_reg, scan_num_next;
    logic [31:0]          scan_max_reg, scan_max_next;

    logic [7:0]           active_limit_reg;
    logic [7:0]           client_limit_reg;
    logic [7:0]           age_limit_reg;
    logic                 count_conn_reg;
    logic                 count_listen_reg;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    cat_pkg::entry_t      wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    cat_pkg::entry_t      rd_data;

    logic                 ignored;
    logic                 same_q;
    logic [7:0]           new_rep;
    logic                 carries;
    logic                 live;
    logic                 aged;
    logic [31:0]          age;

    cat_table #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_limit_reg <= cat_pkg::ACTIVE_LIMIT_RST;
            client_limit_reg <= cat_pkg::CLIENT_LIMIT_RST;
            age_limit_reg    <= cat_pkg::AGE_LIMIT_RST;
            count_conn_reg   <= cat_pkg::COUNT_CONN_RST;
            count_listen_reg <= cat_pkg::COUNT_LISTEN_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                cat_pkg::REG_ACTIVE_LIMIT: active_limit_reg <= pwdata[7:0];
                cat_pkg::REG_CLIENT_LIMIT: client_limit_reg <= pwdata[7:0];
                cat_pkg::REG_AGE_LIMIT:    age_limit_reg    <= pwdata[7:0];
                cat_pkg::REG_COUNT_CONN:   count_conn_reg   <= pwdata[0];
                cat_pkg::REG_COUNT_LISTEN: count_listen_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            cat_pkg::REG_ACTIVE_LIMIT: prdata = {24'd0, active_limit_reg};
            cat_pkg::REG_CLIENT_LIMIT: prdata = {24'd0, client_limit_reg};
            cat_pkg::REG_AGE_LIMIT:    prdata = {24'd0, age_limit_reg};
            cat_pkg::REG_COUNT_CONN:   prdata = {31'd0, count_conn_reg};
            cat_pkg::REG_COUNT_LISTEN: prdata = {31'd0, count_listen_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // Datapath helpers
    assign ignored = (s_data.conn_state != cat_pkg::STATE_ESTABLISHED)
                  || (s_data.remote_addr == cat_pkg::LOOPBACK_ADDR)
                  || (s_data.remote_port == 16'd0);

    assign same_q  = (hit_ent_reg.tx == in_reg.tx_queue) && (hit_ent_reg.rx == in_reg.rx_queue);
    always_comb begin
        if (!same_q) begin
            new_rep = 8'd0;
        end else if (((in_reg.tx_queue != 32'd0) || (in_reg.rx_queue != 32'd0))
                     && (hit_ent_reg.repeats != 8'hFF)) begin
            new_rep = hit_ent_reg.repeats + 8'd1;
        end else begin
            new_rep = hit_ent_reg.repeats;
        end
    end
    assign carries = (new_rep < active_limit_reg) && count_conn_reg;

    assign age  = scan_num_reg - rd_data.last_scan;
    assign live = (rd_data.port != 16'd0);
    assign aged = live && (age > {24'd0, age_limit_reg});

    always_comb begin
        state_next      = state_reg;
        in_next         = in_reg;
        rd_cnt_next     = rd_cnt_reg;
        rdv_next        = 1'b0;
        rd_idx_next     = rd_cnt_reg[IDX_W-1:0];
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_ent_next    = hit_ent_reg;
        act_next        = act_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        scan_num_next   = scan_num_reg;
        scan_max_next   = scan_max_reg;
        wr_en           = 1'b0;
        wr_addr         = rd_idx_reg;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = rd_cnt_reg[IDX_W-1:0];

        case (state_reg)
            S_CLEAR: begin
                wr_en       = 1'b1;
                wr_addr     = rd_cnt_reg[IDX_W-1:0];
                wr_data     = '0;
                rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                if (rd_cnt_reg[IDX_W-1:0] == LAST_IDX) begin
                    rd_cnt_next = '0;
                    state_next  = S_IDLE;
                end
            end
            S_IDLE: begin
                rd_cnt_next = '0;
                if (s_valid) begin
                    in_next         = s_data;
                    free_found_next = 1'b0;
                    act_next        = 1'b0;
                    if (s_data.action == cat_pkg::ACT_SCAN_END) begin
                        state_next = S_END_SCAN;
                    end else if (ignored) begin
                        res_next   = '{cat_pkg::ST_IGNORED, 1'b0, scan_max_reg};
                        state_next = S_RESULT;
                    end else begin
                        state_next = S_OBS_SCAN;
                    end
                end
            end
            S_OBS_SCAN: begin
                if (rd_cnt_reg < CNT_END) begin
                    rd_en       = 1'b1;
                    rdv_next    = 1'b1;
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (rdv_reg) begin
                    if (rd_data.port == in_reg.remote_port) begin
                        hit_next     = 1'b1;
                        hit_idx_next = rd_idx_reg;
                        hit_ent_next = rd_data;
                        state_next   = S_OBS_WRITE;
                    end else begin
                        if (!live && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = rd_idx_reg;
                        end
                        if (rd_idx_reg == LAST_IDX) begin
                            hit_next   = 1'b0;
                            state_next = S_OBS_WRITE;
                        end
                    end
                end
            end
            S_OBS_WRITE: begin
                state_next = S_RESULT;
                if (hit_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = hit_idx_reg;
                    wr_data = '{hit_ent_reg.port, in_reg.tx_queue, in_reg.rx_queue,
                                new_rep, scan_num_reg};
                    if (carries && (in_reg.tx_queue > scan_max_reg)) begin
                        scan_max_next = in_reg.tx_queue;
                        res_next = '{cat_pkg::ST_UPDATED, 1'b0, in_reg.tx_queue};
                    end else begin
                        res_next = '{cat_pkg::ST_UPDATED, 1'b0, scan_max_reg};
                    end
                end else if (free_found_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = free_idx_reg;
                    wr_data = '{in_reg.remote_port, in_reg.tx_queue, in_reg.rx_queue,
                                8'd0, scan_num_reg};
                    res_next = '{cat_pkg::ST_INSERTED, 1'b0, scan_max_reg};
                end else begin
                    res_next = '{cat_pkg::ST_FULL, 1'b0, scan_max_reg};
                end
            end
            S_END_SCAN: begin
                if (rd_cnt_reg < CNT_END) begin
                    rd_en       = 1'b1;
                    rdv_next    = 1'b1;
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (rdv_reg) begin
                    // drop stale entries, note survivors below the client limit
                    if (aged) begin
                        wr_en        = 1'b1;
                        wr_addr      = rd_idx_reg;
                        wr_data      = rd_data;
                        wr_data.port = 16'd0;
                    end
                    if (live && !aged && (rd_data.repeats < client_limit_reg)) begin
                        act_next = 1'b1;
                    end
                    if (rd_idx_reg == LAST_IDX) begin
                        res_next = '{cat_pkg::ST_SCAN_END,
                                     act_reg || (live && !aged
                                                 && (rd_data.repeats < client_limit_reg)),
                                     scan_max_reg};
                        scan_max_next = 32'd0;
                        scan_num_next = scan_num_reg + 32'd1;
                        state_next    = S_RESULT;
                    end
                end
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    rd_cnt_next  = '0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            rd_cnt_reg     <= '0;
            rdv_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            act_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            scan_num_reg   <= 32'd0;
            scan_max_reg   <= 32'd0;
        end else begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            rdv_reg        <= rdv_next;
            free_found_reg <= free_found_next;
            hit_reg        <= hit_next;
            act_reg        <= act_next;
            m_valid_reg    <= m_valid_next;
            scan_num_reg   <= scan_num_next;
            scan_max_reg   <= scan_max_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg       <= in_next;
        rd_idx_reg   <= rd_idx_next;
        free_idx_reg <= free_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_ent_reg  <= hit_ent_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- hw/rtl/cat_table.sv -----
// ----------------------------------------------------------------------------
// cat_table
// Connection table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cat_table #(
    parameter int DEPTH  = cat_pkg::TABLE_ENTRIES,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  cat_pkg::entry_t      wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output cat_pkg::entry_t      rd_data
);

    cat_pkg::entry_t mem [DEPTH];
    cat_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
